### design/daily_temperature_history_macros.svh
// ----------------------------------------------------------------------------
// Daily temperature history: assertion macros
// Shared property wrappers for the checker; clk and rst come from the scope.
// ----------------------------------------------------------------------------
`ifndef DAILY_TEMPERATURE_HISTORY_MACROS_SVH
`define DAILY_TEMPERATURE_HISTORY_MACROS_SVH

// same-cycle implication
`define DTH_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DTH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/dth_pkg.sv
// ----------------------------------------------------------------------------
// Daily temperature history: package
// Op codes, register indexes, reset constants and the stored entry type.
// ----------------------------------------------------------------------------
package dth_pkg;

  localparam int DEPTH_DEFAULT  = 16;
  localparam int PROBES_DEFAULT = 16;

  // item op codes
  localparam logic [2:0] OP_TICK         = 3'd0;
  localparam logic [2:0] OP_CLEAR        = 3'd1;
  localparam logic [2:0] OP_BROWSE_RESET = 3'd2;
  localparam logic [2:0] OP_NEWER        = 3'd3;
  localparam logic [2:0] OP_OLDER        = 3'd4;

  // configuration register indexes
  localparam logic [0:0] REG_ACTUAL_PERIOD = 1'b0;
  localparam logic [0:0] REG_DAY_PERIOD    = 1'b1;

  localparam logic [31:0] ACTUAL_PERIOD_RESET = 32'd1000;
  localparam logic [31:0] DAY_PERIOD_RESET    = 32'd3600000;

  localparam logic signed [15:0] RUN_MIN_RESET    = 16'sd90;
  localparam logic signed [15:0] RUN_MAX_RESET    = -16'sd30;
  localparam logic signed [15:0] PROBE_LOW_RESET  = 16'sh7FFF;
  localparam logic signed [15:0] PROBE_HIGH_RESET = 16'sh8000;

  // one day of history
  typedef struct packed {
    logic signed [15:0] avg;
    logic signed [15:0] low;
    logic signed [15:0] high;
  } entry_t;

endpackage

### design/dth_avg_div.sv
// ----------------------------------------------------------------------------
// Daily temperature history: day average divider
// Probe sum times the reciprocal of PROBES, truncated toward zero.
// ----------------------------------------------------------------------------
module dth_avg_div #(
  parameter int PROBES = dth_pkg::PROBES_DEFAULT,
  localparam int SUM_W = $clog2(PROBES) + 17
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [SUM_W-1:0] sum,
  output logic                    done,
  output logic signed [15:0]      avg
);

  // exact for every magnitude below 2^SUM_W: RECIP = ceil(2^SH / PROBES)
  localparam int LG = $clog2(PROBES);
  localparam int SH = SUM_W + LG;
  localparam int MW = SUM_W + 1;
  localparam int PW = SUM_W + MW;
  localparam logic [63:0] RECIP_WIDE =
    ((64'd1 << SH) + 64'(PROBES) - 64'd1) / 64'(PROBES);
  localparam logic [MW-1:0] RECIP = RECIP_WIDE[MW-1:0];

  logic             busy;
  logic             neg;
  logic [SUM_W-1:0] mag;
  logic [SUM_W-1:0] mag_q;
  logic [PW-1:0]    prod;
  logic [15:0]      quo;

  // magnitude of the signed sum
  assign mag = sum[SUM_W-1] ? (~sum + 1'b1) : sum;

  // constant multiply by the reciprocal
  assign prod = PW'(mag_q) * PW'(RECIP);

  // stage control: operands at start, quotient in the cycle after
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy;
      busy <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg   <= sum[SUM_W-1];
      mag_q <= mag;
    end
    if (busy) quo <= prod[SH+15:SH];
  end

  // quotient is at most 2^15, so 16 bits carry it before the sign goes back on
  assign avg = neg ? (~quo + 1'b1) : quo;

endmodule

### design/daily_temperature_history.sv
// ----------------------------------------------------------------------------
// Daily temperature history
// Running min/max, day probes and a ring of daily average, low and high entries with browsing.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                   Payload
//  item      in         item_valid / item_stall     op, temperature
//  result    out        result_valid / result_stall actual_min .. has_older
//  config    in         cfg_we                      cfg_index, cfg_data
//
//  Ticks, clears, browse resets and browse steps that do not move report from
//  ST_IDLE. A browse step that moves reads the history memory and reports
//  from ST_SHOW. A day event that closes the day waits in ST_DIV for the
//  reciprocal-multiply average and reports with the ring write.
//  Reset is synchronous; history needs no clearing pass, since only entries
//  written since the last clear are ever shown. Behind a held result a skid
//  register takes one more item's result before item_stall rises.
// ----------------------------------------------------------------------------
module daily_temperature_history #(
  parameter int DEPTH  = dth_pkg::DEPTH_DEFAULT,
  parameter int PROBES = dth_pkg::PROBES_DEFAULT,
  localparam int CW    = $clog2(DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [0:0]           cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  logic [2:0]           op,
  input  logic signed [15:0]   temperature,
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic signed [15:0]   actual_min,
  output logic signed [15:0]   actual_max,
  output logic [CW-1:0]        history_count,
  output logic                 entry_valid,
  output logic [CW-1:0]        entry_day,
  output logic signed [15:0]   entry_avg,
  output logic signed [15:0]   entry_min,
  output logic signed [15:0]   entry_max,
  output logic                 has_newer,
  output logic                 has_older
);

  localparam int AW    = $clog2(DEPTH);
  localparam int PCW   = $clog2(PROBES + 1);
  localparam int SUM_W = $clog2(PROBES) + 17;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_SHOW = 2'd2;

  typedef struct packed {
    logic signed [15:0] act_min;
    logic signed [15:0] act_max;
    logic [CW-1:0]      count;
    logic               ent_valid;
    logic [CW-1:0]      day;
    dth_pkg::entry_t    ent;
    logic               newer;
    logic               older;
  } res_t;

  // configuration
  logic [31:0] act_period;
  logic [31:0] day_period;

  // scalar state
  logic [1:0]              state, state_next;
  logic signed [15:0]      run_min, run_min_next;
  logic signed [15:0]      run_max, run_max_next;
  logic [31:0]             act_elapsed, act_elapsed_next;
  logic [31:0]             day_elapsed, day_elapsed_next;
  logic [PCW-1:0]          probe_count, probe_count_next;
  logic signed [SUM_W-1:0] probe_sum, probe_sum_next;
  logic signed [15:0]      probe_low, probe_low_next;
  logic signed [15:0]      probe_high, probe_high_next;
  logic [CW-1:0]           write_index, write_index_next;
  logic                    ring_full, ring_full_next;
  logic [CW-1:0]           browse_pos, browse_pos_next;
  logic signed [15:0]      wr_low;
  logic signed [15:0]      wr_high;

  // history memory
  dth_pkg::entry_t mem [DEPTH];
  dth_pkg::entry_t rd_entry;
  dth_pkg::entry_t wr_entry;
  logic            mem_we;
  logic            rd_en;
  logic [AW-1:0]   wa;

  // result path
  res_t res_q, skid_q, res_n;
  logic res_valid, skid_valid;
  logic produce;
  logic ent_valid;

  // divider
  logic               div_start;
  logic               div_done;
  logic signed [15:0] div_avg;

  logic               accept;
  logic [CW-1:0]      size, size_next, wi;
  logic [31:0]        act_inc, day_inc;

  assign item_stall = (state != ST_IDLE) || skid_valid;
  assign accept     = item_valid && !item_stall;
  assign size       = ring_full ? CW'(DEPTH) : write_index;

  dth_avg_div #(.PROBES(PROBES)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .sum   (probe_sum),
    .done  (div_done),
    .avg   (div_avg)
  );

  // next state of the item processing
  always_comb begin
    state_next       = state;
    run_min_next     = run_min;
    run_max_next     = run_max;
    act_elapsed_next = act_elapsed;
    day_elapsed_next = day_elapsed;
    probe_count_next = probe_count;
    probe_sum_next   = probe_sum;
    probe_low_next   = probe_low;
    probe_high_next  = probe_high;
    write_index_next = write_index;
    ring_full_next   = ring_full;
    browse_pos_next  = browse_pos;
    produce          = 1'b0;
    ent_valid        = 1'b0;
    div_start        = 1'b0;
    mem_we           = 1'b0;
    rd_en            = 1'b0;
    wi               = write_index;
    act_inc          = act_elapsed + 32'd1;
    day_inc          = day_elapsed + 32'd1;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          produce = 1'b1;
          case (op)
            dth_pkg::OP_TICK: begin
              // running min/max first
              if (act_inc >= act_period) begin
                act_elapsed_next = '0;
                if (temperature < run_min) run_min_next = temperature;
                if (temperature > run_max) run_max_next = temperature;
              end else begin
                act_elapsed_next = act_inc;
              end
              // day event: close the day or take a probe
              if (day_inc >= day_period) begin
                day_elapsed_next = '0;
                if (probe_count >= PCW'(PROBES)) begin
                  div_start        = 1'b1;
                  produce          = 1'b0;
                  state_next       = ST_DIV;
                  probe_count_next = '0;
                  probe_sum_next   = '0;
                  probe_low_next   = dth_pkg::PROBE_LOW_RESET;
                  probe_high_next  = dth_pkg::PROBE_HIGH_RESET;
                end else begin
                  probe_count_next = probe_count + 1'b1;
                  probe_sum_next   = probe_sum + SUM_W'(temperature);
                  if (temperature < probe_low)  probe_low_next  = temperature;
                  if (temperature > probe_high) probe_high_next = temperature;
                end
              end else begin
                day_elapsed_next = day_inc;
              end
            end
            dth_pkg::OP_CLEAR: begin
              write_index_next = '0;
              ring_full_next   = 1'b0;
              browse_pos_next  = '0;
            end
            dth_pkg::OP_BROWSE_RESET: begin
              browse_pos_next = size;
            end
            dth_pkg::OP_NEWER: begin
              if (browse_pos != '0) begin
                browse_pos_next = browse_pos - 1'b1;
                rd_en           = 1'b1;
                produce         = 1'b0;
                state_next      = ST_SHOW;
              end
            end
            dth_pkg::OP_OLDER: begin
              if ((CW + 1)'(browse_pos) + 1'b1 < (CW + 1)'(size)) begin
                browse_pos_next = browse_pos + 1'b1;
                rd_en           = 1'b1;
                produce         = 1'b0;
                state_next      = ST_SHOW;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_DIV: begin
        // ring write once the average is ready
        if (div_done) begin
          if (write_index == CW'(DEPTH)) begin
            wi             = '0;
            ring_full_next = 1'b1;
          end
          mem_we           = 1'b1;
          write_index_next = wi + 1'b1;
          produce          = 1'b1;
          state_next       = ST_IDLE;
        end
      end
      ST_SHOW: begin
        produce    = 1'b1;
        ent_valid  = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign wa       = wi[AW-1:0];
  assign wr_entry = '{avg: div_avg, low: wr_low, high: wr_high};

  // result built from the updated state
  always_comb begin
    size_next     = ring_full_next ? CW'(DEPTH) : write_index_next;
    res_n.act_min = run_min_next;
    res_n.act_max = run_max_next;
    res_n.count   = size_next;
    res_n.ent_valid = ent_valid;
    res_n.day     = ent_valid ? (size_next - browse_pos_next) : '0;
    res_n.ent     = ent_valid ? rd_entry : '0;
    res_n.newer   = (browse_pos_next != '0);
    res_n.older   = ((CW + 1)'(browse_pos_next) + 1'b1 < (CW + 1)'(size_next));
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      act_period <= dth_pkg::ACTUAL_PERIOD_RESET;
      day_period <= dth_pkg::DAY_PERIOD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dth_pkg::REG_ACTUAL_PERIOD: act_period <= cfg_data;
        dth_pkg::REG_DAY_PERIOD:    day_period <= cfg_data;
      endcase
    end
  end

  // block state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      run_min     <= dth_pkg::RUN_MIN_RESET;
      run_max     <= dth_pkg::RUN_MAX_RESET;
      act_elapsed <= '0;
      day_elapsed <= '0;
      probe_count <= '0;
      probe_sum   <= '0;
      probe_low   <= dth_pkg::PROBE_LOW_RESET;
      probe_high  <= dth_pkg::PROBE_HIGH_RESET;
      write_index <= '0;
      ring_full   <= 1'b0;
      browse_pos  <= '0;
    end else begin
      state       <= state_next;
      run_min     <= run_min_next;
      run_max     <= run_max_next;
      act_elapsed <= act_elapsed_next;
      day_elapsed <= day_elapsed_next;
      probe_count <= probe_count_next;
      probe_sum   <= probe_sum_next;
      probe_low   <= probe_low_next;
      probe_high  <= probe_high_next;
      write_index <= write_index_next;
      ring_full   <= ring_full_next;
      browse_pos  <= browse_pos_next;
    end
  end

  // day low/high held while the average is divided
  always_ff @(posedge clk) begin
    if (div_start) begin
      wr_low  <= probe_low;
      wr_high <= probe_high;
    end
  end

  // history memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[wa] <= wr_entry;
    if (rd_en)  rd_entry <= mem[browse_pos_next[AW-1:0]];
  end

  // output register with skid
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (produce) begin
      if (!res_valid || !result_stall) begin
        res_q     <= res_n;
        res_valid <= 1'b1;
      end else begin
        skid_q     <= res_n;
        skid_valid <= 1'b1;
      end
    end else if (res_valid && !result_stall) begin
      if (skid_valid) begin
        res_q      <= skid_q;
        skid_valid <= 1'b0;
      end else begin
        res_valid <= 1'b0;
      end
    end
  end

  assign result_valid  = res_valid;
  assign actual_min    = res_q.act_min;
  assign actual_max    = res_q.act_max;
  assign history_count = res_q.count;
  assign entry_valid   = res_q.ent_valid;
  assign entry_day     = res_q.day;
  assign entry_avg     = res_q.ent.avg;
  assign entry_min     = res_q.ent.low;
  assign entry_max     = res_q.ent.high;
  assign has_newer     = res_q.newer;
  assign has_older     = res_q.older;

endmodule

### design/dth_checker.sv
// ----------------------------------------------------------------------------
// Daily temperature history: port checker
// Watches the result channel of the top level; bound in below.
// ----------------------------------------------------------------------------
`include "daily_temperature_history_macros.svh"

module dth_checker #(
  parameter int DEPTH = dth_pkg::DEPTH_DEFAULT,
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input logic               clk,
  input logic               rst,
  input logic               result_valid,
  input logic               result_stall,
  input logic [CW-1:0]      history_count,
  input logic               entry_valid,
  input logic [CW-1:0]      entry_day,
  input logic signed [15:0] entry_avg,
  input logic signed [15:0] entry_min,
  input logic signed [15:0] entry_max,
  input logic               has_older
);

  logic             held;
  logic             shown;
  logic [2*CW+15:0] held_bits;
  logic [CW+47:0]   entry_bits;

  assign held       = result_valid && result_stall;
  assign shown      = result_valid && entry_valid;
  assign held_bits  = {history_count, entry_day, entry_avg};
  assign entry_bits = {entry_day, entry_avg, entry_min, entry_max};

  // a held item stays valid and keeps its count, day and average
  `DTH_ASSERT_NEXT(a_hold, held, result_valid && $stable(held_bits), "held result changed")

  // no entry shown means zeroed entry fields
  `DTH_ASSERT_IMPL(a_zero, result_valid && !entry_valid, entry_bits == '0, "entry fields not zero")

  // count never beyond the ring
  `DTH_ASSERT_IMPL(a_count, result_valid, history_count <= DEPTH, "count beyond depth")

  // a shown day lies inside the history
  `DTH_ASSERT_IMPL(a_day, shown, entry_day != 0 && entry_day <= history_count, "bad entry day")

  // an older entry needs at least two days
  `DTH_ASSERT_IMPL(a_older, result_valid && has_older, history_count > 1, "short history")

endmodule

bind daily_temperature_history dth_checker #(.DEPTH(DEPTH)) u_dth_checker (
  .clk           (clk),
  .rst           (rst),
  .result_valid  (result_valid),
  .result_stall  (result_stall),
  .history_count (history_count),
  .entry_valid   (entry_valid),
  .entry_day     (entry_day),
  .entry_avg     (entry_avg),
  .entry_min     (entry_min),
  .entry_max     (entry_max),
  .has_older     (has_older)
);

### test/tb_daily_temperature_history.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Daily temperature history testbench
// Directed items on an empty and a one-entry ring, then phases of random
// ticks, browse walks and clears under several period settings. A scoreboard
// predicts one report per item and checks every field of each result in
// order. Both channels idle at random; one long receiver hold-off backs up
// the block so that it stalls its input.
// ----------------------------------------------------------------------------
module tb_daily_temperature_history;

  localparam int DEPTH  = dth_pkg::DEPTH_DEFAULT;
  localparam int PROBES = dth_pkg::PROBES_DEFAULT;
  localparam int CW     = $clog2(DEPTH + 1);

  localparam logic [2:0] OP_CODE_MAX = 3'd7;   // top of the op field, 5..7 unused

  localparam int STUCK_LIMIT      = 3000;  // cycles with no handshake on either channel
  localparam int SETTLE_CYCLES    = 40;    // covers the day-close latency
  localparam int SQUEEZE_AT       = 400;   // items sent before the long hold-off
  localparam int SQUEEZE_CYCLES   = 300;

  // one report of the block
  typedef struct packed {
    logic signed [15:0] run_low;
    logic signed [15:0] run_high;
    logic [CW-1:0]      count;
    logic               shown;
    logic [CW-1:0]      day;
    logic signed [15:0] avg;
    logic signed [15:0] low;
    logic signed [15:0] high;
    logic               newer;
    logic               older;
  } report_t;

  // --------------------------------------------------------------------------
  // Scoreboard: history predictor plus the queue of expected reports
  // --------------------------------------------------------------------------
  class history_scoreboard;
    logic [31:0]        actual_period;
    logic [31:0]        day_period;
    logic signed [15:0] run_lo;
    logic signed [15:0] run_hi;
    logic [31:0]        actual_ticks;
    logic [31:0]        day_ticks;
    int unsigned        probes_held;
    int                 probe_total;
    logic signed [15:0] probe_lo;
    logic signed [15:0] probe_hi;
    dth_pkg::entry_t    days [DEPTH];
    int unsigned        wr_slot;
    bit                 wrapped;
    int unsigned        view_pos;
    report_t            expected_q [$];
    int unsigned        errors;

    function new();
      actual_period = dth_pkg::ACTUAL_PERIOD_RESET;
      day_period    = dth_pkg::DAY_PERIOD_RESET;
      run_lo        = dth_pkg::RUN_MIN_RESET;
      run_hi        = dth_pkg::RUN_MAX_RESET;
      actual_ticks  = '0;
      day_ticks     = '0;
      errors        = 0;
      empty_probes();
      clear_days();
    endfunction

    function void empty_probes();
      probes_held = 0;
      probe_total = 0;
      probe_lo    = dth_pkg::PROBE_LOW_RESET;
      probe_hi    = dth_pkg::PROBE_HIGH_RESET;
    endfunction

    function void clear_days();
      foreach (days[i]) begin
        days[i].avg  = '0;
        days[i].low  = dth_pkg::RUN_MIN_RESET;
        days[i].high = dth_pkg::RUN_MAX_RESET;
      end
      wr_slot  = 0;
      wrapped  = 1'b0;
      view_pos = 0;
    endfunction

    function int unsigned ring_size();
      return wrapped ? DEPTH : wr_slot;
    endfunction

    function void write_reg(logic [0:0] idx, logic [31:0] value);
      case (idx)
        dth_pkg::REG_ACTUAL_PERIOD: actual_period = value;
        dth_pkg::REG_DAY_PERIOD:    day_period    = value;
        default: ;
      endcase
    endfunction

    // advance the history by one accepted item and queue its report
    function void note_item(logic [2:0] code, logic signed [15:0] t);
      report_t     r;
      bit          moved;
      int unsigned size;
      moved = 1'b0;
      case (code)
        dth_pkg::OP_TICK: begin
          actual_ticks++;
          if (actual_ticks >= actual_period) begin
            actual_ticks = '0;
            if (t < run_lo) run_lo = t;
            if (t > run_hi) run_hi = t;
          end
          day_ticks++;
          if (day_ticks >= day_period) begin
            day_ticks = '0;
            if (probes_held >= PROBES) begin
              // day closes: no sample, store the summary
              if (wr_slot >= DEPTH) begin
                wr_slot = 0;
                wrapped = 1'b1;
              end
              days[wr_slot].avg  = 16'(probe_total / PROBES);
              days[wr_slot].low  = probe_lo;
              days[wr_slot].high = probe_hi;
              wr_slot++;
              empty_probes();
            end else begin
              probes_held++;
              probe_total += t;
              if (t < probe_lo) probe_lo = t;
              if (t > probe_hi) probe_hi = t;
            end
          end
        end
        dth_pkg::OP_CLEAR:        clear_days();
        dth_pkg::OP_BROWSE_RESET: view_pos = ring_size();
        dth_pkg::OP_NEWER: begin
          if (view_pos > 0) begin
            view_pos--;
            moved = 1'b1;
          end
        end
        dth_pkg::OP_OLDER: begin
          if (view_pos + 1 < ring_size()) begin
            view_pos++;
            moved = 1'b1;
          end
        end
        default: ;
      endcase

      size = ring_size();
      if (view_pos >= DEPTH) moved = 1'b0;
      r = '0;
      r.run_low  = run_lo;
      r.run_high = run_hi;
      r.count    = CW'(size);
      if (moved) begin
        r.shown = 1'b1;
        r.day   = CW'(size - view_pos);
        r.avg   = days[view_pos].avg;
        r.low   = days[view_pos].low;
        r.high  = days[view_pos].high;
      end
      r.newer = (view_pos > 0);
      r.older = (view_pos + 1 < size);
      expected_q.push_back(r);
    endfunction

    function void check_field(string name, int want, int got);
      if (want != got) begin
        errors++;
        $display("%0t mismatch on %s: expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    // compare one accepted result against the oldest expectation
    function void check_result(report_t got);
      report_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t result with no item pending: count %0d", $time, got.count);
        return;
      end
      want = expected_q.pop_front();
      check_field("actual_min",    want.run_low,  got.run_low);
      check_field("actual_max",    want.run_high, got.run_high);
      check_field("history_count", want.count,    got.count);
      check_field("entry_valid",   want.shown,    got.shown);
      check_field("entry_day",     want.day,      got.day);
      check_field("entry_avg",     want.avg,      got.avg);
      check_field("entry_min",     want.low,      got.low);
      check_field("entry_max",     want.high,     got.high);
      check_field("has_newer",     want.newer,    got.newer);
      check_field("has_older",     want.older,    got.older);
    endfunction

    function int unsigned close_out();
      if (expected_q.size() != 0)
        $display("%0t %0d expected results never arrived", $time, expected_q.size());
      return errors + expected_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals and block
  // --------------------------------------------------------------------------
  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [0:0]         cfg_index;
  logic [31:0]        cfg_data;
  logic               item_valid;
  logic               item_stall;
  logic [2:0]         op;
  logic signed [15:0] temperature;
  logic               result_valid;
  logic               result_stall;
  logic signed [15:0] actual_min;
  logic signed [15:0] actual_max;
  logic [CW-1:0]      history_count;
  logic               entry_valid;
  logic [CW-1:0]      entry_day;
  logic signed [15:0] entry_avg;
  logic signed [15:0] entry_min;
  logic signed [15:0] entry_max;
  logic               has_newer;
  logic               has_older;

  history_scoreboard sb;
  int items_sent;
  int reports_taken;
  int send_calm;
  int take_calm;
  int stuck_cycles;
  bit squeezed;

  daily_temperature_history #(.DEPTH(DEPTH), .PROBES(PROBES)) dut (.*);

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------
  // idle length: mostly short, a few long, with calm stretches of none
  function automatic int idle_length(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) calm = $urandom_range(20, 60);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // mostly plausible readings, sometimes the whole 16-bit range
  function automatic logic signed [15:0] pick_temperature(input bit full_range);
    if (full_range || $urandom_range(0, 6) == 0) return 16'($urandom);
    return 16'(int'($urandom_range(0, 150)) - 40);
  endfunction

  task automatic send_item(input logic [2:0] code, input logic signed [15:0] t);
    int gap;
    gap = idle_length(send_calm);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid  <= 1'b1;
    op          <= code;
    temperature <= t;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic program_periods(input logic [31:0] actual, input logic [31:0] day);
    cfg_we    <= 1'b1;
    cfg_index <= dth_pkg::REG_ACTUAL_PERIOD;
    cfg_data  <= actual;
    @(posedge clk);
    cfg_index <= dth_pkg::REG_DAY_PERIOD;
    cfg_data  <= day;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // stop offering, wait for every report, then let the block drain
  task automatic settle();
    item_valid <= 1'b0;
    while (reports_taken != items_sent) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // random mix: ticks, clears, unused op codes, browse walks from the newest entry, single steps
  task automatic run_random(input int count, input bit clears_on, input bit full_range);
    int done;
    int r;
    int steps_back;
    int steps_fwd;
    done = 0;
    while (done < count) begin
      r = $urandom_range(0, 999);
      if (r < 640) begin
        send_item(dth_pkg::OP_TICK, pick_temperature(full_range));
        done++;
      end else if (r < 644) begin
        if (clears_on) begin
          send_item(dth_pkg::OP_CLEAR, 16'($urandom));
          done++;
        end
      end else if (r < 670) begin
        send_item(3'($urandom_range(dth_pkg::OP_OLDER + 1, OP_CODE_MAX)), 16'($urandom));
        done++;
      end else if (r < 760) begin
        steps_back = $urandom_range(1, DEPTH + 2);
        steps_fwd  = $urandom_range(0, DEPTH + 2);
        send_item(dth_pkg::OP_BROWSE_RESET, 16'($urandom));
        repeat (steps_back) send_item(dth_pkg::OP_NEWER, 16'($urandom));
        repeat (steps_fwd) send_item(dth_pkg::OP_OLDER, 16'($urandom));
        done += 1 + steps_back + steps_fwd;
      end else if (r < 780) begin
        send_item(dth_pkg::OP_BROWSE_RESET, 16'($urandom));
        done++;
      end else if (r < 890) begin
        send_item(dth_pkg::OP_NEWER, 16'($urandom));
        done++;
      end else begin
        send_item(dth_pkg::OP_OLDER, 16'($urandom));
        done++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Monitor and watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    report_t seen;
    if (!rst) begin
      if (cfg_we) sb.write_reg(cfg_index, cfg_data);
      if (item_valid && !item_stall) sb.note_item(op, temperature);
      if (result_valid && !result_stall) begin
        seen.run_low  = actual_min;
        seen.run_high = actual_max;
        seen.count    = history_count;
        seen.shown    = entry_valid;
        seen.day      = entry_day;
        seen.avg      = entry_avg;
        seen.low      = entry_min;
        seen.high     = entry_max;
        seen.newer    = has_newer;
        seen.older    = has_older;
        sb.check_result(seen);
        reports_taken++;
      end
      if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT) begin
          $display("%0t no handshake for %0d cycles", $time, STUCK_LIMIT);
          $display("FAIL daily_temperature_history");
          $finish;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stalls plus one long hold-off that backs up the block
  // --------------------------------------------------------------------------
  initial begin : receiver
    int hold;
    hold = 0;
    result_stall <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!squeezed && items_sent >= SQUEEZE_AT) begin
        result_stall <= 1'b1;
        repeat (SQUEEZE_CYCLES) @(posedge clk);
        squeezed = 1'b1;
      end else if (hold > 0) begin
        result_stall <= 1'b1;
        hold--;
      end else begin
        result_stall <= 1'b0;
        hold = idle_length(take_calm);
      end
      @(posedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned faults;
    sb            = new();
    items_sent    = 0;
    reports_taken = 0;
    send_calm     = 0;
    take_calm     = 0;
    stuck_cycles  = 0;
    squeezed      = 1'b0;
    rst         <= 1'b1;
    cfg_we      <= 1'b0;
    cfg_index   <= dth_pkg::REG_ACTUAL_PERIOD;
    cfg_data    <= '0;
    item_valid  <= 1'b0;
    op          <= dth_pkg::OP_TICK;
    temperature <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: running values frozen, every tick is a day event
    program_periods(32'hFFFF_FFFF, 32'd1);
    // browsing an empty ring never moves
    send_item(dth_pkg::OP_NEWER, 16'($urandom));
    send_item(dth_pkg::OP_OLDER, 16'($urandom));
    send_item(dth_pkg::OP_BROWSE_RESET, 16'($urandom));
    send_item(OP_CODE_MAX, 16'($urandom));
    // sixteen probes with the extremes; the sum is negative so the
    // average truncates toward zero
    send_item(dth_pkg::OP_TICK, 16'sh7FFF);
    send_item(dth_pkg::OP_TICK, 16'sh8000);
    send_item(dth_pkg::OP_TICK, -16'sd1);
    send_item(dth_pkg::OP_TICK, 16'sd0);
    send_item(dth_pkg::OP_TICK, 16'sd1);
    repeat (PROBES - 5) send_item(dth_pkg::OP_TICK, -16'sd5);
    // closing event: takes no sample, writes the first entry
    send_item(dth_pkg::OP_TICK, 16'sd123);
    // one-entry ring: only the newest step moves
    send_item(dth_pkg::OP_BROWSE_RESET, 16'($urandom));
    send_item(dth_pkg::OP_OLDER, 16'($urandom));
    send_item(dth_pkg::OP_NEWER, 16'($urandom));
    send_item(dth_pkg::OP_NEWER, 16'($urandom));
    send_item(dth_pkg::OP_CLEAR, 16'($urandom));
    settle();

    // fastest updates, no clears so the ring wraps over the next phases
    program_periods(32'd1, 32'd1);
    run_random(300, 1'b0, 1'b0);
    settle();

    program_periods(32'd3, 32'd2);
    run_random(250, 1'b1, 1'b0);
    settle();

    program_periods(32'hFFFF_FFFF, 32'd1);
    run_random(250, 1'b0, 1'b0);
    settle();

    // no day events: browse the history that is there
    program_periods(32'd2, 32'hFFFF_FFFF);
    run_random(150, 1'b1, 1'b0);
    settle();

    program_periods(32'd5, 32'd3);
    run_random(250, 1'b1, 1'b0);
    settle();

    program_periods(32'd1, 32'd1);
    run_random(200, 1'b0, 1'b1);
    settle();

    faults = sb.close_out();
    if (faults == 0) begin
      $display("PASS daily_temperature_history");
    end else begin
      $display("%0d failures", faults);
      $display("FAIL daily_temperature_history");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/dth_pkg.sv
design/dth_avg_div.sv
design/daily_temperature_history.sv
design/dth_checker.sv
test/tb_daily_temperature_history.sv
